>>> hw/rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, constants and helpers of the deadline timer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 64;
  localparam int DELAY_W     = 48;
  localparam int TAG_W       = 32;
  localparam int THREAD_W    = 16;
  localparam int COUNT_W     = 16;
  localparam int MSTEP_W     = $clog2(COUNT_W);

  localparam logic       OP_WAIT = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [1:0] KIND_RELEASE = 2'd0;
  localparam logic [1:0] KIND_PROGRAM = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [TAG_W-1:0]    waiter;
    logic [THREAD_W-1:0] thread;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Map a queue position to a physical slot of the circular buffer.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/dtq_ram.sv
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/deadline_timer_queue_core.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_core
// Sorted sleep-deadline queue with timer programming.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes a wait request (insert a waiter at time base plus
//   delay) or a timer tick (advance time by interval times expiry count and
//   release all expired waiters). The out_ channel returns released waiters,
//   timer programs and rejects; out_last marks the final result of an item.
//   Entries live in one RAM used as a circular buffer ordered by deadline.
//   Timing: one item at a time; in_ready is high only while idle.
//   A wait reads each later entry and moves it back one slot, then writes
//   the new entry; at the head it also programs the timer. A tick runs the
//   shift-add multiply, advances time, releases each expired waiter, then
//   rearms, or disarms when the queue ends empty; a zero count does nothing.
//   The RAM read is registered, so each step has a read and a compare state.
//   A single output register holds each result; a new item is accepted while
//   it waits, and processing stalls only when another result must be loaded
//   before the receiver takes the pending one.
//   Reset empties the queue, zeroes the time base and disarms the timer; the
//   RAM contents need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadline_timer_queue_core
  import dtq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [TAG_W-1:0]    in_waiter_tag,
  input  logic [THREAD_W-1:0] in_thread_tag,
  input  logic [DELAY_W-1:0]  in_delay_ns,
  input  logic [COUNT_W-1:0]  in_expiry_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [TAG_W-1:0]    out_released_tag,
  output logic [THREAD_W-1:0] out_released_thread,
  output logic [TIME_W-1:0]   out_timer_program_ns,
  output logic                out_last
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_REJECT  = 4'd1;
  localparam logic [3:0] ST_INS_RD  = 4'd2;
  localparam logic [3:0] ST_INS_CMP = 4'd3;
  localparam logic [3:0] ST_INS_HD  = 4'd4;
  localparam logic [3:0] ST_MUL     = 4'd5;
  localparam logic [3:0] ST_ADV     = 4'd6;
  localparam logic [3:0] ST_REL_RD  = 4'd7;
  localparam logic [3:0] ST_REL_CMP = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [TIME_W-1:0]   tb_r, tb_nxt;
  logic [TIME_W-1:0]   armed_r, armed_nxt;
  logic [TIME_W-1:0]   mark_r, mark_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [THREAD_W-1:0] thr_r, thr_nxt;
  logic [DELAY_W-1:0]  delay_r, delay_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0]   acc_r, acc_nxt;
  logic [MSTEP_W-1:0]  step_r, step_nxt;

  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic [TAG_W-1:0]    out_tag_r;
  logic [THREAD_W-1:0] out_thr_r;
  logic [TIME_W-1:0]   out_prog_r;
  logic                out_last_r;

  logic                emit;
  logic [1:0]          emit_kind;
  logic [TAG_W-1:0]    emit_tag;
  logic [THREAD_W-1:0] emit_thr;
  logic [TIME_W-1:0]   emit_prog;
  logic                emit_last;
  logic                slot_free;

  logic                wr_en, rd_en;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  entry_t              wr_data, rd_entry;
  logic [ENTRY_W-1:0]  rd_data;

  assign rd_entry  = entry_t'(rd_data);
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);

  dtq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequence inserts, the multiply, releases and timer programs
  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    head_nxt  = head_r;
    pos_nxt   = pos_r;
    tb_nxt    = tb_r;
    armed_nxt = armed_r;
    mark_nxt  = mark_r;
    tag_nxt   = tag_r;
    thr_nxt   = thr_r;
    delay_nxt = delay_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    step_nxt  = step_r;
    emit      = 1'b0;
    emit_kind = KIND_PROGRAM;
    emit_tag  = '0;
    emit_thr  = '0;
    emit_prog = '0;
    emit_last = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = slot_of(head_r, pos_r[IDX_W-1:0]);
    wr_data   = '{deadline: mark_r, waiter: tag_r, thread: thr_r};
    rd_en     = 1'b0;
    rd_addr   = slot_of(head_r, pos_r[IDX_W-1:0] - IDX_W'(1));

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          tag_nxt   = in_waiter_tag;
          thr_nxt   = in_thread_tag;
          delay_nxt = in_delay_ns;
          mark_nxt  = tb_r + {{(TIME_W-DELAY_W){1'b0}}, in_delay_ns};
          cnt_nxt   = in_expiry_count;
          acc_nxt   = '0;
          step_nxt  = '0;
          pos_nxt   = occ_r;
          if (in_operation == OP_WAIT) begin
            state_nxt = (occ_r == CNT_W'(QUEUE_DEPTH)) ? ST_REJECT : ST_INS_RD;
          end else begin
            state_nxt = (in_expiry_count == '0) ? ST_IDLE : ST_MUL;
          end
        end
      end
      ST_REJECT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = KIND_REJECT;
          emit_tag  = tag_r;
          emit_thr  = thr_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_INS_RD: begin
        // Place new entry at head, or fetch the entry just before the gap
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          occ_nxt   = occ_r + CNT_W'(1);
          armed_nxt = {{(TIME_W-DELAY_W){1'b0}}, delay_r};
          state_nxt = ST_INS_HD;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        // Move a later entry back one slot, or drop the new one in the gap
        wr_en = 1'b1;
        if (rd_entry.deadline > mark_r) begin
          wr_data   = rd_entry;
          pos_nxt   = pos_r - CNT_W'(1);
          state_nxt = ST_INS_RD;
        end else begin
          occ_nxt   = occ_r + CNT_W'(1);
          state_nxt = ST_IDLE;
        end
      end
      ST_INS_HD: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_prog = armed_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        // Shift-add interval times count, most significant count bit first
        acc_nxt  = {acc_r[TIME_W-2:0], 1'b0} + (cnt_r[COUNT_W-1] ? armed_r : '0);
        cnt_nxt  = {cnt_r[COUNT_W-2:0], 1'b0};
        step_nxt = step_r + MSTEP_W'(1);
        if (step_r == MSTEP_W'(COUNT_W - 1)) begin
          state_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        tb_nxt    = tb_r + acc_r;
        state_nxt = ST_REL_RD;
      end
      ST_REL_RD: begin
        rd_addr = head_r;
        if (occ_r == '0) begin
          if (slot_free) begin
            emit      = 1'b1;
            tb_nxt    = '0;
            armed_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_REL_CMP;
        end
      end
      ST_REL_CMP: begin
        // Release an expired head, or rearm to the head deadline
        if (slot_free) begin
          emit = 1'b1;
          if (rd_entry.deadline <= tb_r) begin
            emit_kind = KIND_RELEASE;
            emit_tag  = rd_entry.waiter;
            emit_thr  = rd_entry.thread;
            emit_last = 1'b0;
            occ_nxt   = occ_r - CNT_W'(1);
            head_nxt  = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
            state_nxt = ST_REL_RD;
          end else begin
            armed_nxt = rd_entry.deadline - tb_r;
            emit_prog = rd_entry.deadline - tb_r;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control and time state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r   <= '0;
      head_r  <= '0;
      tb_r    <= '0;
      armed_r <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      head_r  <= head_nxt;
      tb_r    <= tb_nxt;
      armed_r <= armed_nxt;
    end
  end

  // Hold item payload and working values
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    mark_r  <= mark_nxt;
    tag_r   <= tag_nxt;
    thr_r   <= thr_nxt;
    delay_r <= delay_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    step_r  <= step_nxt;
  end

  // Output register: load on emit, clear after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= emit_kind;
      out_tag_r  <= emit_tag;
      out_thr_r  <= emit_thr;
      out_prog_r <= emit_prog;
      out_last_r <= emit_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_released_tag     = out_tag_r;
  assign out_released_thread  = out_thr_r;
  assign out_timer_program_ns = out_prog_r;
  assign out_last             = out_last_r;

  // Occupancy never exceeds the queue depth
  assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  // A reject is only produced on a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_kind == KIND_REJECT) |-> occ_r == CNT_W'(QUEUE_DEPTH))
    else $error("reject on a queue that is not full");

  // A release only happens with an entry present
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_kind == KIND_RELEASE) |-> occ_r != '0)
    else $error("release from an empty queue");

  // Programs and rejects always close their item
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_RELEASE) |-> out_last_r)
    else $error("final result without last");

  // An emit never overwrites a result still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("output register overwritten");

endmodule
